### hw/rtl/tfp_pkg.sv
`default_nettype none
package tfp_pkg;

	localparam int NUM_LABELS = 20;
	localparam int TEXT_BITS = 64;
	localparam int NUM_BITS = 33;
	localparam int FIFO_DEPTH = 2;

	localparam logic [4:0] CODE_PID      = 5'd0;
	localparam logic [4:0] CODE_OR       = 5'd9;
	localparam logic [4:0] CODE_CHECKSUM = 5'd19;
	localparam logic [4:0] CODE_UNKNOWN  = 5'd20;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_LX    = 8'h78;

	localparam logic [32:0] NUM_CAP = 33'h1_0000_0000;

	typedef enum logic [1:0] {
		PH_WAIT,
		PH_LABEL,
		PH_VALUE,
		PH_CKBYTE
	} phase_t;

	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_SIGNED,
		KIND_UNSIGNED
	} kind_t;

	typedef struct packed {
		logic [4:0]           code;
		logic [NUM_BITS-1:0]  accum;
		logic                 neg;
		logic [TEXT_BITS-1:0] text;
		logic [3:0]           len;
		logic                 sum_ok;
	} rec_t;

	localparam logic [63:0] LABEL_NAME [NUM_LABELS] = '{
		64'("PID"), 64'("FW"), 64'("SER#"), 64'("V"), 64'("I"), 64'("VPV"), 64'("PPV"),
		64'("CS"), 64'("MPPT"), 64'("OR"), 64'("ERR"), 64'("LOAD"), 64'("IL"),
		64'("H19"), 64'("H20"), 64'("H21"), 64'("H22"), 64'("H23"), 64'("HSDS"),
		64'("Checksum")
	};

	localparam logic [4:0] LABEL_LEN [NUM_LABELS] = '{
		5'd3, 5'd2, 5'd4, 5'd1, 5'd1, 5'd3, 5'd3, 5'd2, 5'd4, 5'd2,
		5'd3, 5'd4, 5'd2, 5'd3, 5'd3, 5'd3, 5'd3, 5'd3, 5'd4, 5'd8
	};

	function automatic logic [4:0] match_label(input logic [63:0] lbl, input logic [4:0] cnt);
		logic [4:0] code;
		logic       eq;
		int         len;
		code = CODE_UNKNOWN;
		for (int k = NUM_LABELS - 1; k >= 0; k--) begin
			len = int'(LABEL_LEN[k]);
			eq = (cnt == LABEL_LEN[k]);
			for (int i = 0; i < 8; i++) begin
				if (i < len && lbl[8*i +: 8] != LABEL_NAME[k][8*(len-1-i) +: 8]) begin
					eq = 1'b0;
				end
			end
			if (eq) begin
				code = 5'(k);
			end
		end
		return code;
	endfunction

	function automatic kind_t kind_of(input logic [4:0] code);
		kind_t kind;
		case (code)
			5'd3, 5'd4, 5'd5, 5'd6, 5'd12: kind = KIND_SIGNED;
			5'd0, 5'd1, 5'd7, 5'd8, 5'd9, 5'd10,
			5'd13, 5'd14, 5'd15, 5'd16, 5'd17, 5'd18: kind = KIND_UNSIGNED;
			default: kind = KIND_NONE;
		endcase
		return kind;
	endfunction

	function automatic logic [31:0] width_mask(input logic [4:0] code);
		logic [31:0] m;
		case (code)
			5'd0, 5'd1: m = 32'h0000_FFFF;
			5'd7, 5'd8, 5'd10: m = 32'h0000_00FF;
			default: m = 32'hFFFF_FFFF;
		endcase
		return m;
	endfunction

endpackage
`default_nettype wire

### hw/rtl/tfp_front.sv
`default_nettype none
module tfp_front #(
	parameter int LABEL_CHARS = 8,
	parameter int TEXT_CHARS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  rx_byte,
	input  wire logic        last_byte,
	input  wire logic        q_full,
	output logic             q_push,
	output tfp_pkg::rec_t    q_rec
);

	localparam int LCW = $clog2(LABEL_CHARS + 1);

	tfp_pkg::phase_t            phase_q, phase_d;
	logic [LABEL_CHARS*8-1:0]   label_q, label_d;
	logic [LCW-1:0]             lcount_q, lcount_d;
	logic [4:0]                 code_q, code_d;
	logic [32:0]                accum_q, accum_d;
	logic                       neg_q, neg_d;
	logic                       hex_q, hex_d;
	logic                       done_q, done_d;
	logic [1:0]                 stage_q, stage_d;
	logic                       lone_q, lone_d;
	logic [TEXT_CHARS*8-1:0]    text_q, text_d;
	logic [3:0]                 tlen_q, tlen_d;
	logic [7:0]                 sum_q, sum_d;

	logic       accept;
	logic [7:0] c;
	logic [4:0] match;
	logic       is_dig;
	logic [3:0] dval;
	logic [37:0] prod;
	logic [37:0] nxt;
	logic       emit;
	logic       clear_val;

	assign c = rx_byte;
	assign in_ready = !q_full;
	assign accept = in_valid && in_ready;

	always_comb begin
		is_dig = 1'b0;
		dval = 4'd0;
		if (c >= tfp_pkg::CH_0 && c <= tfp_pkg::CH_9) begin
			is_dig = 1'b1;
			dval = 4'(c - tfp_pkg::CH_0);
		end else if (hex_q && c >= tfp_pkg::CH_LA && c <= tfp_pkg::CH_LF) begin
			is_dig = 1'b1;
			dval = 4'(c - tfp_pkg::CH_LA + 8'd10);
		end else if (hex_q && c >= tfp_pkg::CH_UA && c <= tfp_pkg::CH_UF) begin
			is_dig = 1'b1;
			dval = 4'(c - tfp_pkg::CH_UA + 8'd10);
		end
		prod = hex_q ? {1'b0, accum_q, 4'b0} : ({2'b0, accum_q, 3'b0} + {4'b0, accum_q, 1'b0});
		nxt = prod + 38'(dval);
	end

	always_comb begin
		phase_d = phase_q;
		label_d = label_q;
		lcount_d = lcount_q;
		code_d = code_q;
		accum_d = accum_q;
		neg_d = neg_q;
		hex_d = hex_q;
		done_d = done_q;
		stage_d = stage_q;
		lone_d = lone_q;
		text_d = text_q;
		tlen_d = tlen_q;
		sum_d = sum_q + c;
		clear_val = 1'b0;
		emit = 1'b0;
		q_rec = '0;

		case (phase_q)
			tfp_pkg::PH_WAIT: begin
				if (c == tfp_pkg::CH_NL) begin
					phase_d = tfp_pkg::PH_LABEL;
					label_d = '0;
					lcount_d = '0;
					code_d = '0;
					clear_val = 1'b1;
				end
			end
			tfp_pkg::PH_LABEL: begin
				if (c == tfp_pkg::CH_TAB || c == tfp_pkg::CH_CR) begin
					clear_val = 1'b1;
				end else if (lcount_q < LCW'(LABEL_CHARS)) begin
					for (int i = 0; i < LABEL_CHARS; i++) begin
						if (lcount_q == LCW'(i)) begin
							label_d[8*i +: 8] = c;
						end
					end
					lcount_d = lcount_q + 1'b1;
				end
			end
			tfp_pkg::PH_VALUE: begin
				if (c == tfp_pkg::CH_TAB) begin
					clear_val = 1'b1;
				end else if (c != tfp_pkg::CH_CR) begin
					if (tlen_q < 4'(TEXT_CHARS)) begin
						for (int i = 0; i < TEXT_CHARS; i++) begin
							if (tlen_q == 4'(i)) begin
								text_d[8*i +: 8] = c;
							end
						end
						tlen_d = tlen_q + 4'd1;
					end
					if (!done_q) begin
						if (stage_q == 2'd0 && (c == tfp_pkg::CH_SPACE || c == tfp_pkg::CH_NL
								|| c == tfp_pkg::CH_VT || c == tfp_pkg::CH_FF)) begin
							stage_d = stage_q;
						end else if (stage_q == 2'd0 && (c == tfp_pkg::CH_PLUS
								|| c == tfp_pkg::CH_MINUS)) begin
							neg_d = (c == tfp_pkg::CH_MINUS);
							stage_d = 2'd1;
						end else if (stage_q == 2'd2 && lone_q && (c == tfp_pkg::CH_LX
								|| c == tfp_pkg::CH_UX)) begin
							hex_d = 1'b1;
							lone_d = 1'b0;
						end else if (!is_dig) begin
							done_d = 1'b1;
						end else begin
							lone_d = (stage_q != 2'd2) && (c == tfp_pkg::CH_0) && !hex_q
								&& (code_q == tfp_pkg::CODE_PID || code_q == tfp_pkg::CODE_OR);
							stage_d = 2'd2;
							accum_d = (nxt > 38'hFFFF_FFFF) ? tfp_pkg::NUM_CAP : nxt[32:0];
						end
					end
				end
			end
			default: begin
			end
		endcase

		if (clear_val) begin
			accum_d = '0;
			neg_d = 1'b0;
			hex_d = 1'b0;
			done_d = 1'b0;
			stage_d = 2'd0;
			lone_d = 1'b0;
			text_d = '0;
			tlen_d = '0;
		end

		match = tfp_pkg::match_label(label_d[63:0], 5'(lcount_d));

		if (phase_q == tfp_pkg::PH_LABEL && c == tfp_pkg::CH_TAB) begin
			code_d = match;
			phase_d = (match == tfp_pkg::CODE_CHECKSUM) ? tfp_pkg::PH_CKBYTE : tfp_pkg::PH_VALUE;
		end else if (phase_q == tfp_pkg::PH_LABEL && c == tfp_pkg::CH_CR) begin
			code_d = match;
			phase_d = tfp_pkg::PH_WAIT;
		end else if (phase_q == tfp_pkg::PH_VALUE && c == tfp_pkg::CH_CR) begin
			phase_d = tfp_pkg::PH_WAIT;
		end

		q_rec.accum = accum_d;
		q_rec.neg = neg_d;
		q_rec.text = tfp_pkg::TEXT_BITS'(text_d);
		q_rec.len = tlen_d;
		q_rec.sum_ok = (sum_d == 8'd0);
		q_rec.code = (phase_q == tfp_pkg::PH_VALUE) ? code_q : match;

		if (phase_q == tfp_pkg::PH_CKBYTE) begin
			emit = 1'b1;
			q_rec.code = tfp_pkg::CODE_CHECKSUM;
			q_rec.accum = 33'(c);
			q_rec.neg = 1'b0;
			q_rec.text = tfp_pkg::TEXT_BITS'(c);
			q_rec.len = 4'd1;
			phase_d = tfp_pkg::PH_WAIT;
		end else if ((phase_q == tfp_pkg::PH_LABEL || phase_q == tfp_pkg::PH_VALUE)
				&& (c == tfp_pkg::CH_CR || last_byte)) begin
			emit = 1'b1;
		end else if (phase_q == tfp_pkg::PH_WAIT && c == tfp_pkg::CH_NL && last_byte) begin
			emit = 1'b1;
		end

		if (emit && q_rec.code == tfp_pkg::CODE_CHECKSUM) begin
			sum_d = '0;
		end

		if (last_byte) begin
			phase_d = tfp_pkg::PH_WAIT;
			label_d = '0;
			lcount_d = '0;
			code_d = '0;
			accum_d = '0;
			neg_d = 1'b0;
			hex_d = 1'b0;
			done_d = 1'b0;
			stage_d = 2'd0;
			lone_d = 1'b0;
			text_d = '0;
			tlen_d = '0;
			sum_d = '0;
		end

		q_push = accept && emit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tfp_pkg::PH_WAIT;
			label_q <= '0;
			lcount_q <= '0;
			code_q <= '0;
			accum_q <= '0;
			neg_q <= 1'b0;
			hex_q <= 1'b0;
			done_q <= 1'b0;
			stage_q <= 2'd0;
			lone_q <= 1'b0;
			text_q <= '0;
			tlen_q <= '0;
			sum_q <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			label_q <= label_d;
			lcount_q <= lcount_d;
			code_q <= code_d;
			accum_q <= accum_d;
			neg_q <= neg_d;
			hex_q <= hex_d;
			done_q <= done_d;
			stage_q <= stage_d;
			lone_q <= lone_d;
			text_q <= text_d;
			tlen_q <= tlen_d;
			sum_q <= sum_d;
		end
	end

	a_accum_cap: assert property (@(posedge clk) disable iff (!arst_n)
		accum_q <= tfp_pkg::NUM_CAP)
		else $error("accumulator beyond saturation value");
	a_label_len: assert property (@(posedge clk) disable iff (!arst_n)
		lcount_q <= LCW'(LABEL_CHARS))
		else $error("label count out of range");
	a_text_len: assert property (@(posedge clk) disable iff (!arst_n)
		tlen_q <= 4'(TEXT_CHARS))
		else $error("text length out of range");

endmodule
`default_nettype wire

### hw/rtl/tfp_fifo.sv
`default_nettype none
module tfp_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  tfp_pkg::rec_t      wr_rec,
	output logic               full,
	input  wire logic          pop,
	output logic               not_empty,
	output tfp_pkg::rec_t      rd_rec
);

	tfp_pkg::rec_t mem_q [tfp_pkg::FIFO_DEPTH];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] count_q;

	assign full = (count_q == 2'(tfp_pkg::FIFO_DEPTH));
	assign not_empty = (count_q != 2'd0);
	assign rd_rec = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wr_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= !wptr_q;
			end
			if (pop) begin
				rptr_q <= !rptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("push into full queue");
	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n) !(pop && !not_empty))
		else $error("pop from empty queue");
	a_ptr_count: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd1) == (wptr_q != rptr_q))
		else $error("queue pointers disagree with count");

endmodule
`default_nettype wire

### hw/rtl/tfp_back.sv
`default_nettype none
module tfp_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               q_not_empty,
	input  tfp_pkg::rec_t           q_rec,
	output logic                    q_pop,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [4:0]              field_code,
	output logic signed [32:0]      number_value,
	output logic [63:0]             text_chars,
	output logic [3:0]              text_count,
	output logic                    sum_ok,
	output logic                    number_overflow
);

	logic        valid_q;
	logic [4:0]  code_q;
	logic [32:0] num_q;
	logic [63:0] text_q;
	logic [3:0]  cnt_q;
	logic        sum_ok_q;
	logic        ovf_q;

	logic [32:0] num_d;
	logic        ovf_d;
	logic [32:0] mag;
	logic [31:0] uval;
	tfp_pkg::kind_t kind;

	assign q_pop = q_not_empty && (!valid_q || out_ready);

	always_comb begin
		kind = tfp_pkg::kind_of(q_rec.code);
		mag = q_rec.accum;
		num_d = '0;
		ovf_d = 1'b0;
		uval = '0;
		if (q_rec.code == tfp_pkg::CODE_CHECKSUM) begin
			num_d = q_rec.accum;
		end else begin
			case (kind)
				tfp_pkg::KIND_SIGNED: begin
					if (q_rec.neg) begin
						if (mag > 33'h0_8000_0000) begin
							mag = 33'h0_8000_0000;
							ovf_d = 1'b1;
						end
						num_d = 33'd0 - mag;
					end else begin
						if (mag > 33'h0_7FFF_FFFF) begin
							mag = 33'h0_7FFF_FFFF;
							ovf_d = 1'b1;
						end
						num_d = mag;
					end
				end
				tfp_pkg::KIND_UNSIGNED: begin
					if (mag > 33'h0_FFFF_FFFF) begin
						uval = 32'hFFFF_FFFF;
						ovf_d = 1'b1;
					end else begin
						uval = q_rec.neg ? (32'd0 - mag[31:0]) : mag[31:0];
					end
					num_d = {1'b0, uval & tfp_pkg::width_mask(q_rec.code)};
				end
				default: begin
					num_d = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			code_q <= q_rec.code;
			num_q <= num_d;
			text_q <= q_rec.text;
			cnt_q <= q_rec.len;
			sum_ok_q <= (q_rec.code == tfp_pkg::CODE_CHECKSUM) && q_rec.sum_ok;
			ovf_q <= ovf_d;
		end
	end

	assign out_valid = valid_q;
	assign field_code = code_q;
	assign number_value = num_q;
	assign text_chars = text_q;
	assign text_count = cnt_q;
	assign sum_ok = sum_ok_q;
	assign number_overflow = ovf_q;

	a_ovf_numeric: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && ovf_q) |-> (code_q < tfp_pkg::CODE_CHECKSUM))
		else $error("overflow flagged on a non-numeric record");
	a_sum_checksum: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && sum_ok_q) |-> (code_q == tfp_pkg::CODE_CHECKSUM))
		else $error("sum flag on a record other than checksum");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !out_ready) |=> (valid_q && $stable(code_q) && $stable(num_q)))
		else $error("record changed while waiting for transfer");

endmodule
`default_nettype wire

### hw/rtl/text_frame_field_parser.sv
// text telemetry line parser: takes one received byte per transfer and emits one record
// per finished line (label code, converted number, up to TEXT_CHARS text characters,
// checksum flag on the Checksum record). every byte is parsed in the cycle it is accepted,
// so the block takes one byte per clock while the queue is not full; a record leaves through
// a two-entry queue and then an output register. in_ready drops only while the queue is full
// because the consumer holds out_ready low.
`default_nettype none
module text_frame_field_parser #(
	parameter int LABEL_CHARS = 8,
	parameter int TEXT_CHARS = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [7:0]         rx_byte,
	input  wire logic               last_byte,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [4:0]              field_code,
	output logic signed [32:0]      number_value,
	output logic [63:0]             text_chars,
	output logic [3:0]              text_count,
	output logic                    sum_ok,
	output logic                    number_overflow
);

	tfp_pkg::rec_t push_rec;
	tfp_pkg::rec_t head_rec;
	logic          push;
	logic          full;
	logic          pop;
	logic          not_empty;

	tfp_front #(
		.LABEL_CHARS(LABEL_CHARS),
		.TEXT_CHARS(TEXT_CHARS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.last_byte(last_byte),
		.q_full(full),
		.q_push(push),
		.q_rec(push_rec)
	);

	tfp_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wr_rec(push_rec),
		.full(full),
		.pop(pop),
		.not_empty(not_empty),
		.rd_rec(head_rec)
	);

	tfp_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_not_empty(not_empty),
		.q_rec(head_rec),
		.q_pop(pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.field_code(field_code),
		.number_value(number_value),
		.text_chars(text_chars),
		.text_count(text_count),
		.sum_ok(sum_ok),
		.number_overflow(number_overflow)
	);

endmodule
`default_nettype wire
